FILE: rtl/core/sfs_pkg.sv
// Shared types, field widths and codes of the sprite frame sequencer.
// No dependencies; every other file of the block but sfs_divider imports this package.
package sfs_pkg;

   localparam int FRAME_BITS_DEFAULT = 8;

   localparam int ACTION_BITS      = 2;
   localparam int FIELD_FRAME_BITS = 8;
   localparam int TIME_BITS        = 16;
   localparam int ELAPSED_BITS     = 17;
   localparam int COUNT_BITS       = 5;
   localparam int TILE_BITS        = 9;
   localparam int RECT_BITS        = 17;

   localparam int REQ_DATA_BITS = 2 * FIELD_FRAME_BITS;
   localparam int RSP_USED_BITS = FIELD_FRAME_BITS + 4 * RECT_BITS;
   localparam int RSP_DATA_BITS = ((RSP_USED_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_BITS  = RSP_DATA_BITS - RSP_USED_BITS;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_TIME        = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TICK_TIME         = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGES_PER_ROW    = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGES_PER_COLUMN = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TILE_WIDTH        = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TILE_HEIGHT       = 3'd5;

   // Register reset values
   localparam logic [TIME_BITS-1:0]  IMAGE_TIME_RESET  = 16'd30;
   localparam logic [TIME_BITS-1:0]  TICK_TIME_RESET   = 16'd1;
   localparam logic [COUNT_BITS-1:0] PER_ROW_RESET     = 5'd1;
   localparam logic [COUNT_BITS-1:0] PER_COLUMN_RESET  = 5'd1;
   localparam logic [TILE_BITS-1:0]  TILE_WIDTH_RESET  = 9'd16;
   localparam logic [TILE_BITS-1:0]  TILE_HEIGHT_RESET = 9'd16;

   typedef enum logic [ACTION_BITS-1:0] {
      ACT_CYCLE_ALL   = 2'd0,
      ACT_SET_FRAME   = 2'd1,
      ACT_CYCLE_RANGE = 2'd2,
      ACT_ALTERNATE   = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_MOD_WAIT,
      ST_ROW_START,
      ST_ROW_WAIT,
      ST_PRODUCT
   } state_type;

   typedef struct packed {
      logic capture;
      logic update;
      logic div_start;
      logic div_sel_row;
      logic mod_store;
      logic mult_load;
      logic out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic need_mod;
      logic div_done;
      logic out_full;
   } ctrl_status_type;

endpackage

FILE: rtl/core/sfs_divider.sv
// Iterative restoring divider, two quotient bits per cycle.
// Self-contained; used by sfs_datapath for the frame modulo and the row split.
module sfs_divider #(
   parameter int WIDTH = 9
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   output logic             done,
   output logic [WIDTH-1:0] quotient,
   output logic [WIDTH-1:0] remainder
);

   localparam int STEPS    = (WIDTH + 1) / 2;
   localparam int PAD      = 2 * STEPS;
   localparam int CNT_BITS = $clog2(STEPS + 1);

   logic [WIDTH-1:0]    rem_ff, rem_in;
   logic [PAD-1:0]      quo_ff, quo_in;
   logic [WIDTH-1:0]    div_ff;
   logic [CNT_BITS-1:0] cnt_ff;
   logic                done_ff;
   logic [WIDTH:0]      part;
   logic [PAD-1:0]      shift;

   // two restoring steps: shift in the next dividend bit, subtract if it fits
   always_comb begin
      part  = {1'b0, rem_ff};
      shift = quo_ff;
      for (int k = 0; k < 2; k++) begin
         part  = {part[WIDTH-1:0], shift[PAD-1]};
         shift = {shift[PAD-2:0], 1'b0};
         if (part >= {1'b0, div_ff}) begin
            part     = part - {1'b0, div_ff};
            shift[0] = 1'b1;
         end
      end
      rem_in = part[WIDTH-1:0];
      quo_in = shift;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else if (start) begin
         rem_ff  <= '0;
         quo_ff  <= PAD'(dividend);
         div_ff  <= divisor;
         cnt_ff  <= CNT_BITS'(STEPS);
         done_ff <= 1'b0;
      end else if (cnt_ff != '0) begin
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
         cnt_ff  <= cnt_ff - CNT_BITS'(1);
         done_ff <= (cnt_ff == CNT_BITS'(1));
      end else begin
         done_ff <= 1'b0;
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff[WIDTH-1:0];
   assign remainder = rem_ff;

endmodule

FILE: rtl/core/sfs_datapath.sv
// Datapath: registers, timer, frame update, tile rectangle and output stage.
// Depends on sfs_pkg and instantiates sfs_divider.
module sfs_datapath #(
   parameter int FRAME_BITS = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  sfs_pkg::ctrl_cmd_type                cmd,
   output sfs_pkg::ctrl_status_type             status,
   input  logic [sfs_pkg::REQ_DATA_BITS-1:0]    req_tdata,
   input  logic [sfs_pkg::ACTION_BITS-1:0]      req_tuser,
   input  logic                                 csr_write_en,
   input  logic [sfs_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [sfs_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   input  logic                                 rsp_tready,
   output logic                                 rsp_tvalid,
   output logic [sfs_pkg::RSP_DATA_BITS-1:0]    rsp_tdata
);

   import sfs_pkg::*;

   localparam int DIV_BITS  = (FRAME_BITS + 1 > COUNT_BITS) ? FRAME_BITS + 1 : COUNT_BITS;
   localparam int PROD_BITS = 2 * COUNT_BITS;
   localparam logic [PROD_BITS-1:0] FRAME_COUNT = PROD_BITS'(1 << FRAME_BITS);

   logic [TIME_BITS-1:0]     image_time_ff, tick_time_ff;
   logic [COUNT_BITS-1:0]    per_row_ff, per_col_ff;
   logic [TILE_BITS-1:0]     tile_width_ff, tile_height_ff;

   action_type               action_ff;
   logic [FRAME_BITS-1:0]    first_ff, second_ff;
   logic [FRAME_BITS-1:0]    frame_ff, frame_in, frame_upd;
   logic [ELAPSED_BITS-1:0]  elapsed_ff, elapsed_in;

   logic [COUNT_BITS-1:0]    per_row_nz, per_col_nz;
   logic [PROD_BITS-1:0]     count_raw, frame_count;
   logic [ELAPSED_BITS-1:0]  time_sum;
   logic                     timer_due, pair_equal, timed;
   logic [FRAME_BITS-1:0]    frame_low;
   logic [FRAME_BITS:0]      frame_step, frame_plus;

   logic                     div_done;
   logic [DIV_BITS-1:0]      div_dividend, div_divisor, div_quotient, div_remainder;

   logic [RECT_BITS-1:0]     left_prod_ff, top_prod_ff;
   logic [RECT_BITS-1:0]     src_left, src_top, src_right, src_bottom;
   logic                     rsp_valid_ff;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         image_time_ff  <= IMAGE_TIME_RESET;
         tick_time_ff   <= TICK_TIME_RESET;
         per_row_ff     <= PER_ROW_RESET;
         per_col_ff     <= PER_COLUMN_RESET;
         tile_width_ff  <= TILE_WIDTH_RESET;
         tile_height_ff <= TILE_HEIGHT_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_IMAGE_TIME:        image_time_ff  <= csr_wdata;
            CSR_TICK_TIME:         tick_time_ff   <= csr_wdata;
            CSR_IMAGES_PER_ROW:    per_row_ff     <= csr_wdata[COUNT_BITS-1:0];
            CSR_IMAGES_PER_COLUMN: per_col_ff     <= csr_wdata[COUNT_BITS-1:0];
            CSR_TILE_WIDTH:        tile_width_ff  <= csr_wdata[TILE_BITS-1:0];
            CSR_TILE_HEIGHT:       tile_height_ff <= csr_wdata[TILE_BITS-1:0];
            default: ;
         endcase
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff <= action_type'(req_tuser);
         first_ff  <= req_tdata[FRAME_BITS-1:0];
         second_ff <= req_tdata[FIELD_FRAME_BITS +: FRAME_BITS];
      end
   end

   always_comb begin
      per_row_nz  = (per_row_ff == '0) ? COUNT_BITS'(1) : per_row_ff;
      per_col_nz  = (per_col_ff == '0) ? COUNT_BITS'(1) : per_col_ff;
      count_raw   = PROD_BITS'(per_row_nz) * PROD_BITS'(per_col_nz);
      frame_count = (count_raw > FRAME_COUNT) ? FRAME_COUNT : count_raw;

      time_sum   = elapsed_ff + ELAPSED_BITS'(tick_time_ff);
      timer_due  = time_sum >= ELAPSED_BITS'(image_time_ff);
      pair_equal = first_ff == second_ff;
      timed      = (action_ff == ACT_CYCLE_ALL) || (action_ff == ACT_CYCLE_RANGE)
                   || ((action_ff == ACT_ALTERNATE) && !pair_equal);

      frame_low  = (frame_ff < first_ff) ? first_ff : frame_ff;
      frame_step = (FRAME_BITS + 1)'(frame_low) + (FRAME_BITS + 1)'(1);
      frame_plus = (FRAME_BITS + 1)'(frame_ff) + (FRAME_BITS + 1)'(1);

      case (action_ff)
         ACT_CYCLE_ALL:   frame_upd = frame_ff;
         ACT_SET_FRAME:   frame_upd = first_ff;
         ACT_CYCLE_RANGE: begin
            if (!timer_due)
               frame_upd = frame_low;
            else if (frame_step > (FRAME_BITS + 1)'(second_ff))
               frame_upd = first_ff;
            else
               frame_upd = frame_step[FRAME_BITS-1:0];
         end
         default: begin
            if (pair_equal)
               frame_upd = first_ff;
            else if (!timer_due)
               frame_upd = frame_low;
            else
               frame_upd = (frame_low == first_ff) ? second_ff : first_ff;
         end
      endcase

      if (cmd.update)
         frame_in = frame_upd;
      else if (cmd.mod_store)
         frame_in = div_remainder[FRAME_BITS-1:0];
      else
         frame_in = frame_ff;

      if (cmd.update && timed)
         elapsed_in = timer_due ? '0 : time_sum;
      else
         elapsed_in = elapsed_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff   <= '0;
         elapsed_ff <= '0;
      end else begin
         frame_ff   <= frame_in;
         elapsed_ff <= elapsed_in;
      end
   end

   assign div_dividend = cmd.div_sel_row ? DIV_BITS'(frame_ff) : DIV_BITS'(frame_plus);
   assign div_divisor  = cmd.div_sel_row ? DIV_BITS'(per_row_nz) : DIV_BITS'(frame_count);

   sfs_divider #(
      .WIDTH (DIV_BITS)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   // column and row offsets in the sheet
   always_ff @(posedge clock) begin
      if (cmd.mult_load) begin
         left_prod_ff <= RECT_BITS'(div_remainder[COUNT_BITS-1:0]) * RECT_BITS'(tile_width_ff);
         top_prod_ff  <= RECT_BITS'(div_quotient[FRAME_BITS-1:0]) * RECT_BITS'(tile_height_ff);
      end
   end

   assign src_left   = left_prod_ff + RECT_BITS'(1);
   assign src_top    = top_prod_ff + RECT_BITS'(1);
   assign src_right  = src_left + RECT_BITS'(tile_width_ff);
   assign src_bottom = src_top + RECT_BITS'(tile_height_ff) + RECT_BITS'(1);

   // output register
   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (cmd.out_load)
         rsp_valid_ff <= 1'b1;
      else if (rsp_tready)
         rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load)
         rsp_data_ff <= {{RSP_PAD_BITS{1'b0}}, src_bottom, src_right, src_top, src_left,
                         FIELD_FRAME_BITS'(frame_ff)};
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign status.need_mod = (action_ff == ACT_CYCLE_ALL) && timer_due;
   assign status.div_done = div_done;
   assign status.out_full = rsp_valid_ff && !rsp_tready;

   a_out_load_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid_ff)
      else $error("result load did not raise valid");

   a_frame_hold: assert property (@(posedge clock) disable iff (reset)
      !(cmd.update || cmd.mod_store) |=> $stable(frame_ff))
      else $error("frame changed without an update");

   a_timer_clear: assert property (@(posedge clock) disable iff (reset)
      (cmd.update && timed && timer_due) |=> (elapsed_ff == '0))
      else $error("elapsed time not cleared on advance");

endmodule

FILE: rtl/core/sfs_controller.sv
// Sequencing state machine: issues datapath commands per request.
// Depends on sfs_pkg.
module sfs_controller (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  sfs_pkg::ctrl_status_type status,
   output sfs_pkg::ctrl_cmd_type    cmd
);

   import sfs_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= ST_IDLE;
      else
         state_ff <= state_in;
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            if (status.need_mod) begin
               cmd.div_start = 1'b1;
               state_in      = ST_MOD_WAIT;
            end else begin
               state_in = ST_ROW_START;
            end
         end
         ST_MOD_WAIT: begin
            if (status.div_done) begin
               cmd.mod_store = 1'b1;
               state_in      = ST_ROW_START;
            end
         end
         ST_ROW_START: begin
            cmd.div_start   = 1'b1;
            cmd.div_sel_row = 1'b1;
            state_in        = ST_ROW_WAIT;
         end
         ST_ROW_WAIT: begin
            if (status.div_done) begin
               cmd.mult_load = 1'b1;
               state_in      = ST_PRODUCT;
            end
         end
         ST_PRODUCT: begin
            if (!status.out_full) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

FILE: rtl/core/sprite_frame_sequencer.sv
// Sprite sheet frame sequencer. A request passes the states update, frame modulo (only for a
// cycle-all call that advances), row split and product before its result loads; both divisions
// share the two-bit-per-cycle divider. A new request is taken in the cycle after the result
// loads, and loading waits while the previous result is still held by the downstream side.
// Reset (synchronous, active high): registers to defaults, frame and timer to zero, no
// result pending; no clearing pass is needed.
module sprite_frame_sequencer #(
   parameter int FRAME_BITS = sfs_pkg::FRAME_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [7:0] first_frame, [15:8] second_frame
   input  logic [sfs_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   // [1:0] action
   input  logic [sfs_pkg::ACTION_BITS-1:0]    req_tuser,
   // result channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [7:0] frame_index, [24:8] src_left, [41:25] src_top, [58:42] src_right,
   // [75:59] src_bottom, [79:76] zero
   output logic [sfs_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   // register write port
   input  logic                               csr_write_en,
   input  logic [sfs_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [sfs_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   import sfs_pkg::*;

   // Command and status between the sequencer and the datapath
   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   // Sequencer: take one request, update the frame, run the divider for the
   // frame modulo where needed and for the row split, then load the output register.
   sfs_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Datapath: hold the registers and state, compute the tile rectangle and
   // keep the finished result until the downstream transfer.
   sfs_datapath #(
      .FRAME_BITS (FRAME_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .rsp_tready   (rsp_tready),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tdata    (rsp_tdata)
   );

endmodule

FILE: sim/tb_top.sv
// Self-checking bench for the sprite frame sequencer: directed calls, then phases of random runs.
// Holds its own frame/timer/rectangle scoreboard; depends on sfs_pkg and the block's top level.
`timescale 1ns / 100ps

import sfs_pkg::*;

typedef struct packed {
   logic [7:0]  frame;
   logic [16:0] left;
   logic [16:0] top;
   logic [16:0] right;
   logic [16:0] bottom;
} tile_view_type;

class frame_scoreboard;
   logic [15:0] image_time;
   logic [15:0] tick_time;
   logic [4:0]  per_row_reg;
   logic [4:0]  per_col_reg;
   logic [8:0]  tile_w;
   logic [8:0]  tile_h;
   logic [7:0]  frame_now;
   logic [16:0] elapsed;
   tile_view_type expected_q[$];

   function new();
      image_time  = IMAGE_TIME_RESET;
      tick_time   = TICK_TIME_RESET;
      per_row_reg = PER_ROW_RESET;
      per_col_reg = PER_COLUMN_RESET;
      tile_w      = TILE_WIDTH_RESET;
      tile_h      = TILE_HEIGHT_RESET;
      frame_now   = '0;
      elapsed     = '0;
   endfunction

   function void write_reg(logic [CSR_INDEX_BITS-1:0] index, logic [15:0] value);
      case (index)
         CSR_IMAGE_TIME:        image_time  = value;
         CSR_TICK_TIME:         tick_time   = value;
         CSR_IMAGES_PER_ROW:    per_row_reg = value[4:0];
         CSR_IMAGES_PER_COLUMN: per_col_reg = value[4:0];
         CSR_TILE_WIDTH:        tile_w      = value[8:0];
         CSR_TILE_HEIGHT:       tile_h      = value[8:0];
         default: ;
      endcase
   endfunction

   function int rows_across();
      return (per_row_reg == 0) ? 1 : int'(per_row_reg);
   endfunction

   function int frame_count();
      int rows_down;
      int n;
      rows_down = (per_col_reg == 0) ? 1 : int'(per_col_reg);
      n = rows_across() * rows_down;
      return (n > 256) ? 256 : n;
   endfunction

   // Add one tick; clear the accumulator and report an advance when due.
   function bit timer_due();
      elapsed = elapsed + {1'b0, tick_time};
      if (elapsed >= {1'b0, image_time}) begin
         elapsed = '0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function void note_call(action_type act, logic [7:0] first, logic [7:0] second);
      int            frame;
      int            col;
      int            row;
      tile_view_type view;
      frame = int'(frame_now);
      case (act)
         ACT_CYCLE_ALL: begin
            if (timer_due()) frame = (frame + 1) % frame_count();
         end
         ACT_SET_FRAME: begin
            frame = int'(first);
         end
         ACT_CYCLE_RANGE: begin
            if (frame < int'(first)) frame = int'(first);
            if (timer_due()) begin
               frame = frame + 1;
               if (frame > int'(second)) frame = int'(first);
            end
         end
         default: begin
            // equal pair: force the frame, leave the timer alone
            if (first == second) begin
               frame = int'(first);
            end else begin
               if (frame < int'(first)) frame = int'(first);
               if (timer_due()) frame = (frame == int'(first)) ? int'(second) : int'(first);
            end
         end
      endcase
      frame_now   = frame[7:0];
      col         = int'(frame_now) % rows_across();
      row         = int'(frame_now) / rows_across();
      view.frame  = frame_now;
      view.left   = 17'(col * int'(tile_w) + 1);
      view.top    = 17'(row * int'(tile_h) + 1);
      view.right  = view.left + 17'(tile_w);
      view.bottom = view.top + 17'(tile_h) + 17'(1);
      expected_q.push_back(view);
   endfunction

   function bit check_result(logic [RSP_DATA_BITS-1:0] data, output string why);
      tile_view_type want;
      tile_view_type got;
      why = "";
      if (expected_q.size() == 0) begin
         why = $sformatf("result with no call waiting: %h", data);
         return 1'b0;
      end
      want = expected_q.pop_front();
      got  = data[RSP_USED_BITS-1:0];
      // tdata packs frame lowest, so the struct order is reversed
      got.frame  = data[7:0];
      got.left   = data[24:8];
      got.top    = data[41:25];
      got.right  = data[58:42];
      got.bottom = data[75:59];
      if (got.frame !== want.frame)
         why = {why, $sformatf(" frame %0d/%0d", got.frame, want.frame)};
      if (got.left !== want.left)
         why = {why, $sformatf(" left %0d/%0d", got.left, want.left)};
      if (got.top !== want.top)
         why = {why, $sformatf(" top %0d/%0d", got.top, want.top)};
      if (got.right !== want.right)
         why = {why, $sformatf(" right %0d/%0d", got.right, want.right)};
      if (got.bottom !== want.bottom)
         why = {why, $sformatf(" bottom %0d/%0d", got.bottom, want.bottom)};
      return why == "";
   endfunction

   function int pending();
      return expected_q.size();
   endfunction
endclass

module tb_top;

   localparam int STALL_LIMIT = 2000;  // cycles with no transfer on either channel
   localparam int DRAIN_HOLD  = 20;    // beyond the slowest call latency

   logic                       clock;
   logic                       reset;
   logic                       req_tvalid;
   logic                       req_tready;
   logic [REQ_DATA_BITS-1:0]   req_tdata;
   logic [ACTION_BITS-1:0]     req_tuser;
   logic                       rsp_tvalid;
   logic                       rsp_tready;
   logic [RSP_DATA_BITS-1:0]   rsp_tdata;
   logic                       csr_write_en;
   logic [CSR_INDEX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0]   csr_wdata;

   frame_scoreboard sb = new();
   int              errors    = 0;
   int              idle_pct  = 8;
   int              stall_cnt = 0;

   sprite_frame_sequencer u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_write_en(csr_write_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(string msg);
      errors++;
      $display("mismatch at %0t:%s", $time, msg);
   endtask

   // Result side: hold off tready now and then, on the falling edge.
   always @(negedge clock) begin
      rsp_tready = ($urandom_range(99) >= idle_pct);
   end

   // Sample both channels on the rising edge: note each request transfer, check each result
   // transfer, and end the run if the block stops moving.
   always @(posedge clock) begin
      string why;
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_call(action_type'(req_tuser), req_tdata[7:0], req_tdata[15:8]);
         if (rsp_tvalid && rsp_tready) begin
            if (!sb.check_result(rsp_tdata, why)) report_mismatch(why);
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            stall_cnt = 0;
         else
            stall_cnt++;
         if (stall_cnt >= STALL_LIMIT) begin
            $display("watchdog expired with %0d calls outstanding", sb.pending());
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // Present one call and hold it until its transfer; keep tvalid high into the next call
   // unless a random gap lowers it. Starts and ends on a falling edge.
   task automatic send_call(action_type act, logic [7:0] first, logic [7:0] second);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = act;
      req_tdata  = {second, first};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_BITS-1:0] index, int value);
      csr_write_en = 1'b1;
      csr_index    = index;
      csr_wdata    = value[15:0];
      sb.write_reg(index, value[15:0]);
      @(negedge clock);
      csr_write_en = 1'b0;
   endtask

   // Drop tvalid, let every outstanding result arrive, then give the block time to settle.
   task automatic wait_drained();
      req_tvalid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (DRAIN_HOLD) @(negedge clock);
   endtask

   task automatic load_sheet(int img, int tick, int row, int col, int tw, int th);
      wait_drained();
      write_csr(CSR_IMAGE_TIME, img);
      write_csr(CSR_TICK_TIME, tick);
      write_csr(CSR_IMAGES_PER_ROW, row);
      write_csr(CSR_IMAGES_PER_COLUMN, col);
      write_csr(CSR_TILE_WIDTH, tw);
      write_csr(CSR_TILE_HEIGHT, th);
   endtask

   // Frame numbers lean towards the sheet's own frames, with the extremes mixed in.
   function automatic logic [7:0] pick_frame();
      int n;
      n = sb.frame_count();
      case ($urandom_range(9))
         0:       return 8'd0;
         1:       return 8'd255;
         2, 3:    return 8'($urandom_range(255));
         default: return 8'($urandom_range(n - 1));
      endcase
   endfunction

   // Mostly animation loops (one action repeated with fixed frames), the rest single noise calls.
   task automatic play_runs(int n_items);
      int         done;
      int         run_len;
      action_type act;
      logic [7:0] first;
      logic [7:0] second;
      done = 0;
      while (done < n_items) begin
         act = action_type'($urandom_range(3));
         if ($urandom_range(99) < 20) begin
            send_call(act, 8'($urandom_range(255)), 8'($urandom_range(255)));
            done++;
         end else begin
            first = pick_frame();
            if ($urandom_range(9) == 0)
               second = pick_frame();
            else
               second = first + 8'($urandom_range(5));
            run_len = (act == ACT_SET_FRAME) ? 1 : $urandom_range(3, 16);
            repeat (run_len) begin
               send_call(act, first, second);
               done++;
            end
         end
      end
   endtask

   task automatic play_directed();
      // reset settings: slow timer, one tile per row
      send_call(ACT_CYCLE_ALL, 8'd0, 8'd0);
      send_call(ACT_SET_FRAME, 8'd255, 8'd255);
      send_call(ACT_CYCLE_ALL, 8'd0, 8'd0);
      // every timed call advances on a 4 x 4 sheet
      load_sheet(1, 1, 4, 4, 16, 16);
      send_call(ACT_CYCLE_ALL, 8'd0, 8'd0);      // 255 wraps to 0
      send_call(ACT_CYCLE_ALL, 8'd0, 8'd0);
      send_call(ACT_CYCLE_RANGE, 8'd5, 8'd7);    // below start: jump, then step
      send_call(ACT_CYCLE_RANGE, 8'd5, 8'd7);
      send_call(ACT_CYCLE_RANGE, 8'd5, 8'd7);    // past end: back to start
      send_call(ACT_CYCLE_RANGE, 8'd250, 8'd255);
      send_call(ACT_SET_FRAME, 8'd255, 8'd0);
      send_call(ACT_CYCLE_RANGE, 8'd250, 8'd255); // step past the top frame
      send_call(ACT_CYCLE_RANGE, 8'd9, 8'd3);    // end below start
      send_call(ACT_ALTERNATE, 8'd42, 8'd42);    // equal pair skips the timer
      send_call(ACT_ALTERNATE, 8'd3, 8'd200);
      send_call(ACT_ALTERNATE, 8'd3, 8'd200);
      send_call(ACT_ALTERNATE, 8'd3, 8'd200);
      send_call(ACT_ALTERNATE, 8'd100, 8'd20);   // below first: jump, then toggle
      send_call(ACT_ALTERNATE, 8'd100, 8'd20);
      send_call(ACT_ALTERNATE, 8'd0, 8'd255);
      send_call(ACT_SET_FRAME, 8'd0, 8'd255);
      send_call(ACT_CYCLE_ALL, 8'd255, 8'd0);
   endtask

   initial begin
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = '0;
      csr_write_en = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      repeat (11) @(negedge clock);
      reset = 1'b0;

      play_directed();

      load_sheet(1, 1, 4, 4, 16, 16);
      play_runs(150);
      // zero image time, zero counts and zero tile sizes
      load_sheet(0, 0, 0, 0, 0, 0);
      play_runs(120);
      load_sheet(65535, 65535, 31, 31, 511, 511);
      play_runs(150);
      // full-speed stretch on both channels
      idle_pct = 0;
      load_sheet(3, 1, 16, 16, 256, 256);
      play_runs(200);
      idle_pct = 8;
      load_sheet(65535, 1, 5, 3, 7, 9);
      play_runs(100);
      load_sheet(7, 3, 16, 1, 1, 1);
      play_runs(150);
      load_sheet(5, 0, 3, 7, 100, 200);
      play_runs(80);
      load_sheet(2, 1, 1, 16, 255, 3);
      play_runs(150);
      repeat (3) begin
         load_sheet(($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(12),
                    ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(6),
                    $urandom_range(31), $urandom_range(31),
                    $urandom_range(511), $urandom_range(511));
         play_runs(130);
      end

      wait_drained();
      if (errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
